### src/vmc_pkg.sv
// Shared types, codes and sizes of the vending machine controller.
// Used by the top level and by its port checker; depends on nothing.
package vmc_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int NUM_PRODUCTS = 26;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_IDX_W   = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;

    localparam logic [5:0]  CAPACITY_RESET = 6'd50;
    localparam logic [3:0]  PRICE_MAX      = 4'd9;
    localparam logic [6:0]  COUNT_MAX      = 7'd99;
    localparam logic [11:0] DUE_MAX        = 12'd4095;
    localparam logic [3:0]  COIN_ONE       = 4'd1;
    localparam logic [3:0]  COIN_TWO       = 4'd2;
    localparam logic [3:0]  COIN_FIVE      = 4'd5;

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    typedef enum logic [2:0] {
        CMD_PLACE  = 3'd0,
        CMD_SELECT = 3'd1,
        CMD_END    = 3'd2,
        CMD_COIN   = 3'd3,
        CMD_QUIT   = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_BAD_CHANNEL    = 4'd1,
        ST_OTHER_PRODUCT  = 4'd2,
        ST_PRICE          = 4'd3,
        ST_CAPACITY       = 4'd4,
        ST_SHORT          = 4'd5,
        ST_NOT_IN_CHANNEL = 4'd6,
        ST_BAD_COIN       = 4'd7,
        ST_WRONG_PHASE    = 4'd8,
        ST_PAID           = 4'd9,
        ST_FINISHED       = 4'd10
    } status_t;

    // Phase codes as they appear on the result beat.
    localparam logic [1:0] PHC_LOAD   = 2'd0;
    localparam logic [1:0] PHC_SELECT = 2'd1;
    localparam logic [1:0] PHC_PAY    = 2'd2;
    localparam logic [1:0] PHC_STOP   = 2'd3;

    typedef enum logic [3:0] {
        PH_LOAD   = 4'b0001,
        PH_SELECT = 4'b0010,
        PH_PAY    = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_LOAD:   code = PHC_LOAD;
            PH_SELECT: code = PHC_SELECT;
            PH_PAY:    code = PHC_PAY;
            PH_STOP:   code = PHC_STOP;
            default:   code = PHC_STOP;
        endcase
        return code;
    endfunction

endpackage

### src/vending_machine_controller_top.sv
// Top level of the vending machine controller: command stream in, result stream out,
// capacity register on an APB-style port. Depends on vmc_pkg.

// The controller takes one command beat per cycle on the s_ stream while the result side
// is not stalled, and answers every command with exactly one result beat on the m_
// stream. A command first lands in an input register; once the result register is free,
// one pass of table logic checks it against the channel, price and payment state,
// updates that state and loads the result register. The sustained rate is one command
// per cycle while m_tready is high, set by that single pass; the input and result
// registers let a new command enter while a finished result still waits to be taken.
// Each result reports the status of the command, the phase after it, the amount due,
// the change given when a payment completes, and the stock left in the addressed
// channel. The channel capacity register sits at byte address 0 and should only be
// written while no command is in flight. There is no clearing sequence after reset:
// the reset itself clears the machine state and loads the capacity reset value.
module vending_machine_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // product[4:0], channel[7:5], unit_price[11:8],
                                   // item_count[18:12], coin_value[22:19], zero[23]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // phase[1:0], amount_due[13:2], change_out[16:14],
                                   // channel_stock[22:17], zero[23]
    output logic [3:0]  m_tuser,   // status[3:0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vmc_pkg::*;

    // Configuration register.
    logic [5:0] capacity_reg;

    // Input register.
    logic       in_valid_reg;
    logic [2:0] cmd_reg;
    logic [4:0] prod_reg;
    logic [2:0] ch_reg;
    logic [3:0] price_reg;
    logic [6:0] n_reg;
    logic [3:0] coin_reg;

    // Result register.
    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [1:0]  phase_out_reg;
    logic [11:0] due_out_reg;
    logic [2:0]  change_reg;
    logic [5:0]  stock_out_reg;

    // Machine state.
    phase_t     phase_reg, phase_next;
    logic [4:0] chan_prod_reg  [NUM_CHANNELS];
    logic       chan_used_reg  [NUM_CHANNELS];
    logic [5:0] chan_cnt_reg   [NUM_CHANNELS];
    logic [3:0] prod_price_reg [NUM_PRODUCTS];
    logic [11:0] due_reg, due_next;
    logic [12:0] paid_reg, paid_next;
    logic [8:0]  stock_total_reg, stock_total_next;

    // Handshake control.
    logic advance;
    logic fire;

    // Combinational results of the current command.
    logic                  ch_ok;
    logic                  prod_ok;
    logic [CH_IDX_W-1:0]   ch_idx;
    logic [PROD_IDX_W-1:0] prod_idx;
    logic [4:0]            prod_sel;
    logic                  used_sel;
    logic [5:0]            cnt_sel;
    logic [3:0]            price_sel;
    logic [7:0]            fill_sum;
    logic [9:0]            cost;
    logic [12:0]           due_sum;
    logic [12:0]           paid_sum;
    logic [12:0]           paid_eff;
    logic                  settle;
    logic                  chan_wr;
    logic                  price_wr;
    logic [5:0]            cnt_new;
    status_t               status_next;
    logic [2:0]            change_next;
    logic [5:0]            stock_next;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, stock_out_reg, change_reg, due_out_reg, phase_out_reg};

    // APB port: always ready, one register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {26'd0, capacity_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
            capacity_reg <= pwdata[5:0];
        end
    end

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            prod_reg  <= s_tdata[4:0];
            ch_reg    <= s_tdata[7:5];
            price_reg <= s_tdata[11:8];
            n_reg     <= s_tdata[18:12];
            coin_reg  <= s_tdata[22:19];
        end
    end

    // Table lookups for the addressed channel and product.
    assign ch_ok     = (int'(ch_reg) >= 1) && (int'(ch_reg) <= NUM_CHANNELS);
    assign prod_ok   = int'(prod_reg) < NUM_PRODUCTS;
    assign ch_idx    = CH_IDX_W'(ch_reg - 3'd1);
    assign prod_idx  = PROD_IDX_W'(prod_reg);
    assign prod_sel  = ch_ok ? chan_prod_reg[ch_idx] : 5'd0;
    assign used_sel  = ch_ok ? chan_used_reg[ch_idx] : 1'b0;
    assign cnt_sel   = ch_ok ? chan_cnt_reg[ch_idx] : 6'd0;
    assign price_sel = prod_ok ? prod_price_reg[prod_idx] : 4'd0;
    assign fill_sum  = {2'b00, cnt_sel} + {1'b0, n_reg};
    assign cost      = 10'(price_sel) * 10'(n_reg[5:0]);
    assign due_sum   = {1'b0, due_reg} + 13'(cost);
    assign paid_sum  = paid_reg + 13'(coin_reg);

    // One pass over the command: checks in priority order, then the state update.
    always_comb begin
        phase_next       = phase_reg;
        due_next         = due_reg;
        paid_next        = paid_reg;
        stock_total_next = stock_total_reg;
        status_next      = ST_WRONG_PHASE;
        settle           = 1'b0;
        paid_eff         = paid_reg;
        chan_wr          = 1'b0;
        price_wr         = 1'b0;
        cnt_new          = cnt_sel;
        change_next      = 3'd0;

        if (phase_reg == PH_STOP) begin
            status_next = ST_FINISHED;
        end else if (cmd_reg == CMD_QUIT) begin
            phase_next  = PH_STOP;
            status_next = ST_FINISHED;
        end else begin
            case (cmd_reg)
                CMD_PLACE: begin
                    if (phase_reg == PH_LOAD) begin
                        if (!prod_ok) begin
                            status_next = ST_NOT_IN_CHANNEL;
                        end else if (!ch_ok) begin
                            status_next = ST_BAD_CHANNEL;
                        end else if (used_sel && prod_sel != prod_reg) begin
                            status_next = ST_OTHER_PRODUCT;
                        end else if (price_reg > PRICE_MAX) begin
                            status_next = ST_PRICE;
                        end else if (price_sel != 4'd0 && price_sel != price_reg) begin
                            status_next = ST_PRICE;
                        end else if (n_reg > COUNT_MAX) begin
                            status_next = ST_CAPACITY;
                        end else if (fill_sum > {2'b00, capacity_reg}) begin
                            status_next = ST_CAPACITY;
                        end else begin
                            status_next      = ST_OK;
                            chan_wr          = 1'b1;
                            price_wr         = 1'b1;
                            cnt_new          = fill_sum[5:0];
                            stock_total_next = stock_total_reg + 9'(n_reg);
                        end
                    end
                end
                CMD_SELECT: begin
                    if (phase_reg == PH_SELECT) begin
                        if (!prod_ok) begin
                            status_next = ST_NOT_IN_CHANNEL;
                        end else if (!ch_ok) begin
                            status_next = ST_BAD_CHANNEL;
                        end else if (!used_sel || prod_sel != prod_reg) begin
                            status_next = ST_NOT_IN_CHANNEL;
                        end else if (n_reg > {1'b0, cnt_sel}) begin
                            status_next = ST_SHORT;
                        end else begin
                            status_next      = ST_OK;
                            chan_wr          = 1'b1;
                            cnt_new          = cnt_sel - n_reg[5:0];
                            stock_total_next = stock_total_reg - 9'(n_reg);
                            due_next         = (due_sum > {1'b0, DUE_MAX}) ? DUE_MAX
                                                                           : due_sum[11:0];
                        end
                    end
                end
                CMD_END: begin
                    if (phase_reg == PH_LOAD) begin
                        phase_next  = PH_SELECT;
                        status_next = ST_OK;
                    end else if (phase_reg == PH_SELECT) begin
                        paid_next = 13'd0;
                        paid_eff  = 13'd0;
                        if (due_reg == 12'd0) begin
                            settle = 1'b1;
                        end else begin
                            phase_next  = PH_PAY;
                            status_next = ST_OK;
                        end
                    end
                end
                CMD_COIN: begin
                    if (phase_reg == PH_PAY) begin
                        if (coin_reg != COIN_ONE && coin_reg != COIN_TWO &&
                            coin_reg != COIN_FIVE) begin
                            status_next = ST_BAD_COIN;
                        end else begin
                            paid_next = paid_sum;
                            paid_eff  = paid_sum;
                            if (paid_sum >= {1'b0, due_reg}) begin
                                settle = 1'b1;
                            end else begin
                                status_next = ST_OK;
                            end
                        end
                    end
                end
                default: begin
                    status_next = ST_WRONG_PHASE;
                end
            endcase
        end

        // Payment completes: hand back the change and clear the running totals.
        if (settle) begin
            status_next = ST_PAID;
            change_next = (paid_eff >= {1'b0, due_reg}) ? 3'(paid_eff - {1'b0, due_reg})
                                                        : 3'd0;
            due_next    = 12'd0;
            paid_next   = 13'd0;
            phase_next  = (stock_total_reg == 9'd0) ? PH_STOP : PH_SELECT;
        end

        stock_next = ch_ok ? cnt_new : 6'd0;
    end

    // State update and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_LOAD;
            due_reg         <= 12'd0;
            paid_reg        <= 13'd0;
            stock_total_reg <= 9'd0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_prod_reg[i] <= 5'd0;
                chan_used_reg[i] <= 1'b0;
                chan_cnt_reg[i]  <= 6'd0;
            end
            for (int j = 0; j < NUM_PRODUCTS; j++) begin
                prod_price_reg[j] <= 4'd0;
            end
        end else if (fire) begin
            phase_reg       <= phase_next;
            due_reg         <= due_next;
            paid_reg        <= paid_next;
            stock_total_reg <= stock_total_next;
            if (chan_wr) begin
                chan_prod_reg[ch_idx] <= prod_reg;
                chan_used_reg[ch_idx] <= 1'b1;
                chan_cnt_reg[ch_idx]  <= cnt_new;
            end
            if (price_wr) begin
                prod_price_reg[prod_idx] <= price_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg    <= status_next;
            phase_out_reg <= phase_code(phase_next);
            due_out_reg   <= due_next;
            change_reg    <= change_next;
            stock_out_reg <= stock_next;
        end
    end

endmodule

### src/vmc_checker.sv
// Port-level checker for the vending machine controller and its bind to the top level.
// Depends on vmc_pkg and on vending_machine_controller_top.
module vmc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser
);
    import vmc_pkg::*;

    logic       stopped_seen_reg;
    logic [1:0] phase_f;
    logic [2:0] change_f;

    assign phase_f  = m_tdata[1:0];
    assign change_f = m_tdata[16:14];

    // Remembers that a delivered result reported the stopped phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && phase_f == PHC_STOP) begin
            stopped_seen_reg <= 1'b1;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_stop_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stopped_seen_reg |-> phase_f == PHC_STOP && m_tuser == ST_FINISHED)
        else $error("machine left the stopped phase");

    a_paid_clears_due: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_PAID |->
            m_tdata[13:2] == 12'd0 && (phase_f == PHC_SELECT || phase_f == PHC_STOP))
        else $error("completed payment left an amount due or a bad phase");

    a_change_only_when_paid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && change_f != 3'd0 |-> m_tuser == ST_PAID && change_f <= 3'd4)
        else $error("change given outside a completed payment");

endmodule

bind vending_machine_controller_top vmc_checker u_vmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/vending_machine_controller_top_tb.sv
// Self-checking testbench for vending_machine_controller_top: command beats in, result beats
// checked against a cycle-free model of the controller kept inside this file.
// Depends on vmc_pkg for the command, status and phase codes and on the top level RTL.
module vending_machine_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmc_pkg::*;

    // Random sessions stop issuing new work once this many commands have gone in.
    localparam int ITEM_BUDGET = 1300;
    localparam logic [5:0] CAP_LOWEST  = 6'd1;
    localparam logic [5:0] CAP_HIGHEST = 6'd63;
    localparam logic [4:0] LAST_PROD   = 5'(NUM_PRODUCTS - 1);
    localparam logic [2:0] SPARE_CHAN  = 3'(NUM_CHANNELS);

    // One result beat as the model predicts it.
    typedef struct {
        status_t     status;
        logic [1:0]  phase;
        logic [11:0] due;
        logic [2:0]  change;
        logic [5:0]  stock;
    } vend_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // product[4:0], channel[7:5], unit_price[11:8],
                                  // item_count[18:12], coin_value[22:19], zero[23]
    logic [2:0]  s_tuser  = '0;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // phase[1:0], amount_due[13:2], change_out[16:14],
                                  // channel_stock[22:17], zero[23]
    logic [3:0]  m_tuser;         // status[3:0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model state of the controller, advanced once per accepted command beat.
    logic [5:0]  cap_q = CAPACITY_RESET;
    logic [1:0]  ph_q  = PHC_LOAD;
    logic [4:0]  chan_prod  [NUM_CHANNELS] = '{default: '0};
    logic        chan_used  [NUM_CHANNELS] = '{default: 1'b0};
    int unsigned chan_cnt   [NUM_CHANNELS] = '{default: 0};
    logic [3:0]  prod_price [NUM_PRODUCTS] = '{default: '0};
    int unsigned due_q   = 0;
    int unsigned paid_q  = 0;
    int unsigned stock_q = 0;

    vend_reply_t replies_owed[$];
    int fail_count = 0;
    int cmds_sent  = 0;
    // When set, the matching side runs without idle cycles.
    bit calm_sender   = 1'b0;
    bit calm_receiver = 1'b0;

    vending_machine_controller_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Closes a payment: works out the change and leaves the paying phase.
    function automatic logic [2:0] settle_bill();
        logic [2:0] chg;
        chg = (paid_q >= due_q) ? 3'(paid_q - due_q) : 3'd0;
        due_q  = 0;
        paid_q = 0;
        ph_q   = (stock_q == 0) ? PHC_STOP : PHC_SELECT;
        return chg;
    endfunction

    // Applies one command to the model and returns the result beat it must produce.
    function automatic vend_reply_t compute_reply(input logic [2:0] cmd, input logic [4:0] prod,
            input logic [2:0] ch, input logic [3:0] price, input logic [6:0] n,
            input logic [3:0] coin);
        vend_reply_t r;
        int unsigned c;
        r.status = ST_WRONG_PHASE;
        r.change = '0;
        c = (ch >= 1) ? ch - 1 : 0;
        if (ph_q == PHC_STOP) begin
            r.status = ST_FINISHED;
        end else if (cmd == CMD_QUIT) begin
            ph_q = PHC_STOP;
            r.status = ST_FINISHED;
        end else if (cmd == CMD_PLACE && ph_q == PHC_LOAD) begin
            // The checks run in a fixed order; the first one that fails decides the status.
            if (prod >= NUM_PRODUCTS) begin
                r.status = ST_NOT_IN_CHANNEL;
            end else if (ch < 1 || ch > NUM_CHANNELS) begin
                r.status = ST_BAD_CHANNEL;
            end else if (chan_used[c] && chan_prod[c] != prod) begin
                r.status = ST_OTHER_PRODUCT;
            end else if (price > PRICE_MAX ||
                         (prod_price[prod] != 0 && prod_price[prod] != price)) begin
                r.status = ST_PRICE;
            end else if (n > COUNT_MAX || chan_cnt[c] + n > cap_q) begin
                r.status = ST_CAPACITY;
            end else begin
                chan_cnt[c]      += n;
                stock_q          += n;
                chan_prod[c]      = prod;
                chan_used[c]      = 1'b1;
                prod_price[prod]  = price;
                r.status = ST_OK;
            end
        end else if (cmd == CMD_SELECT && ph_q == PHC_SELECT) begin
            if (prod >= NUM_PRODUCTS) begin
                r.status = ST_NOT_IN_CHANNEL;
            end else if (ch < 1 || ch > NUM_CHANNELS) begin
                r.status = ST_BAD_CHANNEL;
            end else if (!chan_used[c] || chan_prod[c] != prod) begin
                r.status = ST_NOT_IN_CHANNEL;
            end else if (n > chan_cnt[c]) begin
                r.status = ST_SHORT;
            end else begin
                chan_cnt[c] -= n;
                stock_q     -= n;
                due_q       += prod_price[prod] * n;
                if (due_q > DUE_MAX) begin
                    due_q = DUE_MAX;
                end
                r.status = ST_OK;
            end
        end else if (cmd == CMD_END && ph_q == PHC_LOAD) begin
            ph_q = PHC_SELECT;
            r.status = ST_OK;
        end else if (cmd == CMD_END && ph_q == PHC_SELECT) begin
            paid_q = 0;
            if (due_q == 0) begin
                r.change = settle_bill();
                r.status = ST_PAID;
            end else begin
                ph_q = PHC_PAY;
                r.status = ST_OK;
            end
        end else if (cmd == CMD_COIN && ph_q == PHC_PAY) begin
            if (coin != COIN_ONE && coin != COIN_TWO && coin != COIN_FIVE) begin
                r.status = ST_BAD_COIN;
            end else begin
                paid_q += coin;
                if (paid_q >= due_q) begin
                    r.change = settle_bill();
                    r.status = ST_PAID;
                end else begin
                    r.status = ST_OK;
                end
            end
        end
        r.phase = ph_q;
        r.due   = 12'(due_q);
        r.stock = (ch >= 1 && ch <= NUM_CHANNELS) ? 6'(chan_cnt[c]) : 6'd0;
        return r;
    endfunction

    // Sends one command beat after a random gap and records its expected result once the
    // beat has been taken.
    task automatic push_command(input logic [2:0] cmd, input logic [4:0] prod,
            input logic [2:0] ch, input logic [3:0] price, input logic [6:0] n,
            input logic [3:0] coin);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, coin, n, price, ch, prod};
        do @(posedge aclk); while (s_tready !== 1'b1);
        replies_owed.push_back(compute_reply(cmd, prod, ch, price, n, coin));
        cmds_sent++;
    endtask

    // A command whose operand fields are all random.
    task automatic push_op(input logic [2:0] cmd);
        push_command(cmd, 5'($urandom), 3'($urandom), 4'($urandom), 7'($urandom),
                     4'($urandom));
    endtask

    // Random junk that never ends a phase or quits, so sessions keep their shape.
    task automatic push_noise();
        logic [2:0] cmd;
        logic [2:0] ch;
        do cmd = 3'($urandom); while (cmd == CMD_QUIT || cmd == CMD_END);
        ch = 3'($urandom);
        // The last channel is kept empty through loading, so that selects can find it empty.
        if (cmd == CMD_PLACE && ch == SPARE_CHAN) begin
            ch = SPARE_CHAN + 3'd1;
        end
        push_command(cmd, 5'($urandom), ch, 4'($urandom), 7'($urandom), 4'($urandom));
    endtask

    // A placement that passes the product and price checks and mostly fits the channel.
    task automatic push_good_place();
        int unsigned c;
        int unsigned room;
        int unsigned n;
        logic [4:0]  prod;
        logic [3:0]  price;
        c     = $urandom_range(0, NUM_CHANNELS - 2);
        prod  = chan_used[c] ? chan_prod[c] : 5'($urandom_range(0, NUM_PRODUCTS - 1));
        price = (prod_price[prod] != 0) ? prod_price[prod] : 4'($urandom_range(0, PRICE_MAX));
        room  = (chan_cnt[c] < cap_q) ? cap_q - chan_cnt[c] : 0;
        n     = ($urandom_range(0, 7) == 0) ? room + 1 : $urandom_range(0, room);
        push_command(CMD_PLACE, prod, 3'(c + 1), price, 7'(n), 4'($urandom));
    endtask

    // Stops sending and waits until every result beat has come back.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (replies_owed.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_capacity(input logic [5:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {26'd0, want}) begin
            fail_count++;
            $display("%0t ns: capacity read expected %0d, got %0d", $time, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes the capacity register (junk in the unused upper bits) and reads it back.
    task automatic set_capacity(input logic [5:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {26'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        cap_q = value;
        check_capacity(value);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic test_capacity_reset();
        check_capacity(CAPACITY_RESET);
    endtask

    // Each placement check once, in the order the controller applies them.
    task automatic test_place_rules();
        push_command(CMD_PLACE, LAST_PROD, 3'd1, PRICE_MAX, 7'd0, 4'd0);         // zero items
        push_command(CMD_PLACE, LAST_PROD + 5'd1, 3'd1, PRICE_MAX, 7'd1, 4'd0);  // bad product
        push_command(CMD_PLACE, 5'd3, 3'd0, 4'd1, 7'd1, 4'd0);                   // channel 0
        push_command(CMD_PLACE, 5'd3, 3'd7, 4'd1, 7'd1, 4'd0);                   // channel 7
        push_command(CMD_PLACE, 5'd3, 3'd1, 4'd1, 7'd1, 4'd0);                   // other product
        push_command(CMD_PLACE, LAST_PROD, 3'd1, PRICE_MAX + 4'd1, 7'd1, 4'd0);  // price too high
        push_command(CMD_PLACE, LAST_PROD, 3'd2, 4'd4, 7'd1, 4'd0);              // price conflict
        push_command(CMD_PLACE, LAST_PROD, 3'd2, PRICE_MAX, COUNT_MAX + 7'd1, 4'd0);
        push_command(CMD_PLACE, LAST_PROD, 3'd1, PRICE_MAX, 7'(CAPACITY_RESET), 4'd0);
        push_command(CMD_PLACE, LAST_PROD, 3'd1, PRICE_MAX, 7'd1, 4'd0);         // channel full
        push_op(CMD_SELECT);
        push_op(CMD_COIN);
        push_op(CMD_QUIT + 3'd3);
    endtask

    // Loading under the lowest, a random and the highest capacity.
    task automatic test_loading_capacities();
        logic [5:0] caps [3];
        caps = '{CAP_LOWEST, 6'($urandom_range(2, 62)), CAP_HIGHEST};
        foreach (caps[k]) begin
            wait_quiet();
            set_capacity(caps[k]);
            calm_sender   = (k == 1);
            calm_receiver = (k == 2);
            repeat (60 + 30 * k) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_noise();
                end else begin
                    push_good_place();
                end
            end
        end
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
    endtask

    // Leaves loading, then walks the select checks and one payment with change.
    task automatic test_select_rules();
        push_op(CMD_END);
        push_command(CMD_SELECT, 5'h1f, 3'd1, 4'd0, 7'd1, 4'd0);                  // bad product
        push_command(CMD_SELECT, LAST_PROD, 3'd0, 4'd0, 7'd1, 4'd0);             // channel 0
        push_command(CMD_SELECT, LAST_PROD - 5'd1, 3'd1, 4'd0, 7'd1, 4'd0);      // wrong product
        push_command(CMD_SELECT, LAST_PROD, SPARE_CHAN, 4'd0, 7'd1, 4'd0);       // empty channel
        push_command(CMD_SELECT, LAST_PROD, 3'd1, 4'd0, 7'h7f, 4'd0);            // short stock
        push_op(CMD_END);                                                        // nothing due
        push_command(CMD_SELECT, LAST_PROD, 3'd1, 4'd0, 7'd1, 4'd0);
        push_op(CMD_END);
        push_op(CMD_END);                                                        // end while paying
        push_command(CMD_COIN, 5'd0, 3'd1, 4'd0, 7'd0, 4'hf);                    // bad coin
        push_command(CMD_COIN, 5'd0, 3'd1, 4'd0, 7'd0, COIN_TWO);
        push_command(CMD_COIN, 5'd0, 3'd1, 4'd0, 7'd0, COIN_FIVE);
        push_command(CMD_COIN, 5'd0, 3'd1, 4'd0, 7'd0, COIN_FIVE);               // change of 3
    endtask

    // Shopping rounds: a few selects, end, then coins until paid, with junk mixed in.
    task automatic test_random_sessions();
        int sessions;
        int picks;
        int unsigned c;
        int unsigned n;
        sessions = 0;
        while (cmds_sent < ITEM_BUDGET && ph_q == PHC_SELECT) begin
            calm_sender   = ($urandom_range(0, 4) == 0);
            calm_receiver = ($urandom_range(0, 4) == 0);
            if (sessions % 25 == 24) begin
                wait_quiet();
                set_capacity(6'($urandom_range(CAP_LOWEST, CAP_HIGHEST)));
            end else if (sessions % 10 == 9) begin
                wait_quiet();
            end
            picks = $urandom_range(0, 3);
            repeat (picks) begin
                if ($urandom_range(0, 9) < 7) begin
                    do c = $urandom_range(0, NUM_CHANNELS - 1); while (!chan_used[c]);
                    n = $urandom_range(0, 3);
                    // Keep some stock back so that the run does not end early.
                    if (n > chan_cnt[c] || stock_q <= 6) begin
                        n = 0;
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        n = chan_cnt[c] + $urandom_range(1, 20);
                    end
                    push_command(CMD_SELECT, chan_prod[c], 3'(c + 1), 4'($urandom), 7'(n),
                                 4'($urandom));
                end else begin
                    push_noise();
                end
            end
            push_op(CMD_END);
            while (ph_q == PHC_PAY) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: push_command(CMD_COIN, 5'($urandom), 3'($urandom),
                                          4'($urandom), 7'($urandom), COIN_FIVE);
                    6:       push_command(CMD_COIN, 5'($urandom), 3'($urandom),
                                          4'($urandom), 7'($urandom), COIN_ONE);
                    7:       push_command(CMD_COIN, 5'($urandom), 3'($urandom),
                                          4'($urandom), 7'($urandom), COIN_TWO);
                    8:       push_op(CMD_COIN);
                    default: push_op(($urandom_range(0, 1) == 0) ? CMD_END : CMD_SELECT);
                endcase
            end
            sessions++;
        end
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
    endtask

    // Ends the machine either by selling every item or by a quit, then checks that every
    // command code is refused once stopped.
    task automatic test_stop_paths();
        wait_quiet();
        if (ph_q == PHC_SELECT && $urandom_range(0, 1) == 0) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (chan_cnt[c] > 0) begin
                    push_command(CMD_SELECT, chan_prod[c], 3'(c + 1), 4'($urandom),
                                 7'(chan_cnt[c]), 4'($urandom));
                end
            end
            push_op(CMD_END);
            while (ph_q == PHC_PAY) begin
                push_command(CMD_COIN, 5'($urandom), 3'($urandom), 4'($urandom),
                             7'($urandom), COIN_FIVE);
            end
        end else if (ph_q == PHC_SELECT) begin
            push_command(CMD_SELECT, chan_prod[0], 3'd1, 4'd0, 7'(chan_cnt[0] > 0), 4'd0);
            push_op(CMD_END);
            push_op(CMD_QUIT);
        end
        for (int k = 0; k < (1 << $bits(s_tuser)); k++) begin
            push_op(3'(k));
        end
    endtask

    // Result side: stalls at random and compares each beat with the oldest prediction.
    initial begin : result_checker
        vend_reply_t want;
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = calm_receiver ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (replies_owed.size() == 0) begin
                fail_count++;
                $display("%0t ns: result beat with none expected, status %0d", $time, m_tuser);
            end else begin
                want = replies_owed.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("phase", want.phase, m_tdata[1:0]);
                check_field("amount_due", want.due, m_tdata[13:2]);
                check_field("change_out", want.change, m_tdata[16:14]);
                check_field("channel_stock", want.stock, m_tdata[22:17]);
                check_field("tdata pad", 0, m_tdata[23]);
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_capacity_reset();
        test_place_rules();
        test_loading_capacities();
        test_select_rules();
        test_random_sessions();
        test_stop_paths();
        wait_quiet();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // A correct run needs a couple of milliseconds at most; this is several times that.
    initial begin : watchdog
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
src/vmc_pkg.sv
src/vending_machine_controller_top.sv
src/vmc_checker.sv
dv/vending_machine_controller_top_tb.sv
